/* rtl/mcpi_brk_pkg.sv */
`timescale 1ns / 1ps

package mcpi_brk_pkg;

    // Default channel count
    localparam int CHANNELS_DEF = 3;

    // Only this channel may run the brake position loop
    localparam logic [1:0] BRAKE_CH = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CURRENT_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_CURRENT_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_INTEGRATOR_LIMIT = 3'd2;
    localparam logic [2:0] REG_DUTY_LIMIT       = 3'd3;
    localparam logic [2:0] REG_BRAKE_GAIN_P     = 3'd4;
    localparam logic [2:0] REG_BRAKE_GAIN_D     = 3'd5;
    localparam logic [2:0] REG_BRAKE_GAIN_I     = 3'd6;

    // Register values after reset
    localparam logic [31:0] CURRENT_GAIN_P_RST   = 32'd21845;
    localparam logic [31:0] CURRENT_GAIN_I_RST   = 32'd2185;
    localparam logic [14:0] INTEGRATOR_LIMIT_RST = 15'd3072;
    localparam logic [15:0] DUTY_LIMIT_RST       = 16'd32768;
    localparam logic [31:0] BRAKE_GAIN_RST       = 32'd0;

    // Full scale duty, Q1.15
    localparam logic [15:0] FULL_SCALE = 16'h8000;

    // Feedforward terms: 2 ohm / 12 V and 4 * (0.18 V s / 12 V), Q16.16
    localparam logic signed [14:0] FF_RES = 15'sd10923;
    localparam logic signed [12:0] FF_KT4 = 13'sd3932;

    // Current conversion: amps = 15 - raw * 30 / 65536, Q5.10
    localparam logic [19:0]        CUR_SCALE  = 20'd15;
    localparam logic [19:0]        CUR_ROUND  = 20'd16;
    localparam logic signed [16:0] CUR_OFFSET = 17'sd15360;

    // Rounding constants for the two output scalings
    localparam logic [58:0] RND_NORMAL = 59'd1024;
    localparam logic [58:0] RND_BRAKE  = 59'd4096;

endpackage

/* rtl/motor_current_pi_with_brake_unit.sv */
`timescale 1ns / 1ps
// An accepted item passes the input, operand, product, sum and result registers in order.
// Throughput: one item per cycle while results are taken; each stage holds or moves on
// its own, so input is accepted while a result waits, until every stage is full.
// The loop state (per-channel integrator, brake sum and last error) updates on operand load.
// Reset (rst_n low, asynchronous): registers return to defaults, the integrators
// and brake state clear to zero, and the pipeline empties.

module motor_current_pi_with_brake_unit #(
    parameter int CHANNELS = mcpi_brk_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[1:0], current_sample[17:2], speed[33:18], target_current[49:34],
    // angle_error[65:50], zero[71:66]
    input  logic [71:0] s_axis_tdata,
    // brake_request[0]
    input  logic        s_axis_tuser,

    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_channel[1:0], duty[17:2], direction[18], limited[19], zero[23:20]
    output logic [23:0] m_axis_tdata,

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0] current_gain_p_reg;
    logic [31:0] current_gain_i_reg;
    logic [14:0] integrator_limit_reg;
    logic [15:0] duty_limit_reg;
    logic [31:0] brake_gain_p_reg;
    logic [31:0] brake_gain_d_reg;
    logic [31:0] brake_gain_i_reg;

    assign cfg_ready = 1'b1;

    // Write the addressed register; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_p_reg   <= mcpi_brk_pkg::CURRENT_GAIN_P_RST;
            current_gain_i_reg   <= mcpi_brk_pkg::CURRENT_GAIN_I_RST;
            integrator_limit_reg <= mcpi_brk_pkg::INTEGRATOR_LIMIT_RST;
            duty_limit_reg       <= mcpi_brk_pkg::DUTY_LIMIT_RST;
            brake_gain_p_reg     <= mcpi_brk_pkg::BRAKE_GAIN_RST;
            brake_gain_d_reg     <= mcpi_brk_pkg::BRAKE_GAIN_RST;
            brake_gain_i_reg     <= mcpi_brk_pkg::BRAKE_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mcpi_brk_pkg::REG_CURRENT_GAIN_P:   current_gain_p_reg   <= cfg_data;
                mcpi_brk_pkg::REG_CURRENT_GAIN_I:   current_gain_i_reg   <= cfg_data;
                mcpi_brk_pkg::REG_INTEGRATOR_LIMIT: integrator_limit_reg <= cfg_data[14:0];
                mcpi_brk_pkg::REG_DUTY_LIMIT:       duty_limit_reg       <= cfg_data[15:0];
                mcpi_brk_pkg::REG_BRAKE_GAIN_P:     brake_gain_p_reg     <= cfg_data;
                mcpi_brk_pkg::REG_BRAKE_GAIN_D:     brake_gain_d_reg     <= cfg_data;
                mcpi_brk_pkg::REG_BRAKE_GAIN_I:     brake_gain_i_reg     <= cfg_data;
                default:                            ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline handshake
    // ---------------------------------------------------------------
    logic in_v_reg, op_v_reg, prod_v_reg, sum_v_reg, out_v_reg;
    logic op_ld, prod_ld, sum_ld, out_ld;
    logic in_take, chan_ok;

    // A stage loads when it is empty or its content moves on in the same cycle.
    assign out_ld  = sum_v_reg  && (!out_v_reg  || m_axis_tready);
    assign sum_ld  = prod_v_reg && (!sum_v_reg  || out_ld);
    assign prod_ld = op_v_reg   && (!prod_v_reg || sum_ld);
    assign op_ld   = in_v_reg   && (!op_v_reg   || prod_ld);

    assign s_axis_tready = !in_v_reg || op_ld;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    // Items for a channel that does not exist are taken and dropped.
    assign chan_ok       = 32'(s_axis_tdata[1:0]) < CHANNELS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            op_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_v_reg <= chan_ok;
            else if (op_ld)
                in_v_reg <= 1'b0;

            if (op_ld)
                op_v_reg <= 1'b1;
            else if (prod_ld)
                op_v_reg <= 1'b0;

            if (prod_ld)
                prod_v_reg <= 1'b1;
            else if (sum_ld)
                prod_v_reg <= 1'b0;

            if (sum_ld)
                sum_v_reg <= 1'b1;
            else if (out_ld)
                sum_v_reg <= 1'b0;

            if (out_ld)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic [1:0]         in_ch_reg;
    logic [15:0]        in_raw_reg;
    logic signed [15:0] in_speed_reg;
    logic signed [15:0] in_target_reg;
    logic               in_brake_reg;
    logic signed [15:0] in_aerr_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg     <= s_axis_tdata[1:0];
            in_raw_reg    <= s_axis_tdata[17:2];
            in_speed_reg  <= s_axis_tdata[33:18];
            in_target_reg <= s_axis_tdata[49:34];
            in_brake_reg  <= s_axis_tuser;
            in_aerr_reg   <= s_axis_tdata[65:50];
        end
    end

    // ---------------------------------------------------------------
    // Loop state update: integrator clamp and saturating brake sum
    // ---------------------------------------------------------------
    logic signed [15:0] err_int_reg [CHANNELS];
    logic signed [23:0] brake_sum_reg;
    logic signed [15:0] brake_last_reg;

    logic [3:0]           ch_ext;
    logic [CH_IDX_W-1:0]  ch_idx;
    logic                 brake_sel;
    logic [19:0]          raw_scaled;
    logic signed [16:0]   cur;
    logic signed [16:0]   err;
    logic signed [17:0]   integ_sum;
    logic signed [17:0]   ilim_pos;
    logic signed [17:0]   ilim_neg;
    logic signed [17:0]   integ_clamped;
    logic signed [15:0]   integ_next;
    logic signed [24:0]   bsum_wide;
    logic signed [23:0]   bsum_next;
    logic signed [16:0]   bdiff;

    assign ch_ext    = 4'(in_ch_reg);
    assign ch_idx    = ch_ext[CH_IDX_W-1:0];
    assign brake_sel = in_brake_reg && (in_ch_reg == mcpi_brk_pkg::BRAKE_CH);

    // Raw reading to amperes
    assign raw_scaled = 20'(in_raw_reg) * mcpi_brk_pkg::CUR_SCALE + mcpi_brk_pkg::CUR_ROUND;
    assign cur = mcpi_brk_pkg::CUR_OFFSET - $signed({2'b00, raw_scaled[19:5]});
    assign err = 17'(in_target_reg) - cur;

    // Integrator with symmetric clamp
    assign integ_sum = 18'(err_int_reg[ch_idx]) + 18'(err);
    assign ilim_pos  = $signed({3'b000, integrator_limit_reg});
    assign ilim_neg  = 18'sd0 - ilim_pos;

    always_comb
    begin
        if (integ_sum > ilim_pos)
            integ_clamped = ilim_pos;
        else if (integ_sum < ilim_neg)
            integ_clamped = ilim_neg;
        else
            integ_clamped = integ_sum;
    end

    assign integ_next = integ_clamped[15:0];

    // Brake error sum saturates to 24 bits
    assign bsum_wide = 25'(brake_sum_reg) + 25'(in_aerr_reg);

    always_comb
    begin
        if (bsum_wide[24] != bsum_wide[23])
            bsum_next = bsum_wide[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        else
            bsum_next = bsum_wide[23:0];
    end

    assign bdiff = 17'(in_aerr_reg) - 17'(brake_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                err_int_reg[i] <= 16'sd0;
            brake_sum_reg  <= 24'sd0;
            brake_last_reg <= 16'sd0;
        end
        else if (op_ld)
        begin
            if (brake_sel)
            begin
                brake_sum_reg  <= bsum_next;
                brake_last_reg <= in_aerr_reg;
            end
            else
            begin
                err_int_reg[ch_idx] <= integ_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Operand register: mode picks the multiplier operands
    // ---------------------------------------------------------------
    logic               op_brake_reg;
    logic [1:0]         op_ch_reg;
    logic               op_zero_reg;
    logic signed [16:0] op_x1_reg;
    logic signed [16:0] op_x2_reg;
    logic signed [23:0] op_x3_reg;
    logic signed [15:0] op_target_reg;
    logic signed [15:0] op_speed_reg;

    always_ff @(posedge clk)
    begin
        if (op_ld)
        begin
            op_brake_reg <= brake_sel;
            op_ch_reg    <= in_ch_reg;
            op_zero_reg  <= !brake_sel && (in_target_reg == 16'sd0);
            if (brake_sel)
            begin
                op_x1_reg     <= 17'(in_aerr_reg);
                op_x2_reg     <= bdiff;
                op_x3_reg     <= bsum_next;
                op_target_reg <= 16'sd0;
                op_speed_reg  <= 16'sd0;
            end
            else
            begin
                op_x1_reg     <= err;
                op_x2_reg     <= 17'(integ_next);
                op_x3_reg     <= 24'sd0;
                op_target_reg <= in_target_reg;
                op_speed_reg  <= in_speed_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Product register
    // ---------------------------------------------------------------
    logic [31:0]        g1, g2;
    logic signed [49:0] prod1_reg, prod2_reg;
    logic signed [56:0] prod3_reg;
    logic signed [30:0] prod4_reg;
    logic signed [28:0] prod5_reg;
    logic               prod_brake_reg;
    logic [1:0]         prod_ch_reg;
    logic               prod_zero_reg;

    assign g1 = op_brake_reg ? brake_gain_p_reg : current_gain_p_reg;
    assign g2 = op_brake_reg ? brake_gain_d_reg : current_gain_i_reg;

    always_ff @(posedge clk)
    begin
        if (prod_ld)
        begin
            prod1_reg      <= $signed({1'b0, g1}) * op_x1_reg;
            prod2_reg      <= $signed({1'b0, g2}) * op_x2_reg;
            prod3_reg      <= $signed({1'b0, brake_gain_i_reg}) * op_x3_reg;
            prod4_reg      <= mcpi_brk_pkg::FF_RES * op_target_reg;
            prod5_reg      <= mcpi_brk_pkg::FF_KT4 * op_speed_reg;
            prod_brake_reg <= op_brake_reg;
            prod_ch_reg    <= op_ch_reg;
            prod_zero_reg  <= op_zero_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sum register
    // ---------------------------------------------------------------
    logic signed [57:0] sum_reg;
    logic               sum_brake_reg;
    logic [1:0]         sum_ch_reg;
    logic               sum_zero_reg;

    always_ff @(posedge clk)
    begin
        if (sum_ld)
        begin
            sum_reg       <= 58'(prod1_reg) + 58'(prod2_reg) + 58'(prod3_reg)
                           + 58'(prod4_reg) + 58'(prod5_reg);
            sum_brake_reg <= prod_brake_reg;
            sum_ch_reg    <= prod_ch_reg;
            sum_zero_reg  <= prod_zero_reg;
        end
    end

    // ---------------------------------------------------------------
    // Magnitude, rounding half away from zero, duty clamp and zero-target override
    // ---------------------------------------------------------------
    logic        neg;
    logic [57:0] mag_pre;
    logic [58:0] rnd_add;
    logic [58:0] mag_rnd;
    logic [47:0] mag_shift;
    logic [15:0] dlim;
    logic [15:0] duty_cap;
    logic [15:0] duty_next;
    logic        dir_next;
    logic        lim_next;

    assign neg     = sum_reg[57];
    // For a negative sum, ~s + 1 is |s|; the 1 joins the rounding constant.
    assign mag_pre = neg ? ~sum_reg : sum_reg;
    assign rnd_add = (sum_brake_reg ? mcpi_brk_pkg::RND_BRAKE : mcpi_brk_pkg::RND_NORMAL)
                   + 59'(neg);
    assign mag_rnd = {1'b0, mag_pre} + rnd_add;
    assign mag_shift = sum_brake_reg ? 48'(mag_rnd[58:13]) : mag_rnd[58:11];

    assign dlim = (duty_limit_reg > mcpi_brk_pkg::FULL_SCALE) ? mcpi_brk_pkg::FULL_SCALE
                                                              : duty_limit_reg;
    assign duty_cap = sum_brake_reg ? mcpi_brk_pkg::FULL_SCALE : dlim;

    always_comb
    begin
        if (sum_zero_reg)
        begin
            duty_next = 16'd0;
            dir_next  = 1'b1;
            lim_next  = 1'b0;
        end
        else if (mag_shift > 48'(duty_cap))
        begin
            duty_next = duty_cap;
            dir_next  = neg;
            lim_next  = 1'b1;
        end
        else
        begin
            duty_next = mag_shift[15:0];
            dir_next  = neg;
            lim_next  = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [1:0]  out_ch_reg;
    logic [15:0] out_duty_reg;
    logic        out_dir_reg;
    logic        out_lim_reg;
    logic        out_brake_reg;

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            out_ch_reg    <= sum_ch_reg;
            out_duty_reg  <= duty_next;
            out_dir_reg   <= dir_next;
            out_lim_reg   <= lim_next;
            out_brake_reg <= sum_brake_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {4'd0, out_lim_reg, out_dir_reg, out_duty_reg, out_ch_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A result never exceeds full scale duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_duty_reg <= mcpi_brk_pkg::FULL_SCALE))
        else $error("duty above full scale");

    // A clamped result sits exactly at the limit of its mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_lim_reg) |->
            ((out_brake_reg && (out_duty_reg == mcpi_brk_pkg::FULL_SCALE)) ||
             (!out_brake_reg && (out_duty_reg == dlim))))
        else $error("limited flag without duty at its limit");

    // An item for a missing channel never enters the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && !chan_ok) |=> !in_v_reg)
        else $error("item for missing channel entered the pipeline");

    // With every stage full and the output stalled, no item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && op_v_reg && prod_v_reg && sum_v_reg && out_v_reg && !m_axis_tready)
            |-> !s_axis_tready)
        else $error("input accepted while the pipeline is full");

    // The brake's last error changes only when a brake item passes the state stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(op_ld && brake_sel) |=> $stable(brake_last_reg))
        else $error("brake state changed without a brake item");

endmodule

/* bench/motor_current_pi_with_brake_unit_test.sv */
`timescale 1ns / 1ps

module motor_current_pi_with_brake_unit_test;

    localparam int NUM_CH      = mcpi_brk_pkg::CHANNELS_DEF;
    localparam int IDLE_CYCLES = 12;
    localparam int QUIET_LIMIT = 4000;

    // One expected drive command, with the fields of the result item.
    typedef struct packed {
        logic [1:0]  chan;
        logic [15:0] duty;
        logic        dir;
        logic        lim;
    } drive_cmd_t;

    // Scoreboard: predicts the drive command for each accepted sample on an existing
    // channel and compares the block's commands against the oldest prediction.
    class drive_scoreboard;
        localparam int BRAKE_CHAN    = 2;
        localparam int DUTY_FULL     = 32768;
        localparam int FF_RES_GAIN   = 10923;
        localparam int FF_SPEED_GAIN = 3932;
        localparam int TOTAL_MAX     = 8388607;
        localparam int TOTAL_MIN     = -8388608;

        logic [31:0] gain_p, gain_i, brk_kp, brk_kd, brk_ki;
        logic [14:0] integ_limit;
        logic [15:0] duty_cap;
        int          integ[NUM_CH];
        int          brk_total;
        int          brk_last;
        drive_cmd_t  pending[$];
        int          errors;
        int          checked;

        function new();
            gain_p      = 32'd21845;
            gain_i      = 32'd2185;
            integ_limit = 15'd3072;
            duty_cap    = 16'd32768;
            brk_kp      = '0;
            brk_kd      = '0;
            brk_ki      = '0;
            foreach (integ[i])
                integ[i] = 0;
            brk_total = 0;
            brk_last  = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] val);
            case (idx)
                mcpi_brk_pkg::REG_CURRENT_GAIN_P:   gain_p      = val;
                mcpi_brk_pkg::REG_CURRENT_GAIN_I:   gain_i      = val;
                mcpi_brk_pkg::REG_INTEGRATOR_LIMIT: integ_limit = val[14:0];
                mcpi_brk_pkg::REG_DUTY_LIMIT:       duty_cap    = val[15:0];
                mcpi_brk_pkg::REG_BRAKE_GAIN_P:     brk_kp      = val;
                mcpi_brk_pkg::REG_BRAKE_GAIN_D:     brk_kd      = val;
                mcpi_brk_pkg::REG_BRAKE_GAIN_I:     brk_ki      = val;
                default: ;
            endcase
        endfunction

        // Magnitude of a wide sum, shifted down with round half away from zero.
        function longint unsigned round_mag(longint v, int sh);
            longint unsigned m;
            if (v < 0)
                m = -v;
            else
                m = v;
            return (m + (64'd1 << (sh - 1))) >> sh;
        endfunction

        function void note_sample(logic [1:0] chan, logic [15:0] raw,
                                  logic signed [15:0] speed, logic signed [15:0] target,
                                  logic brake, logic signed [15:0] aerr);
            drive_cmd_t       cmd;
            longint           acc;
            longint unsigned  mag;
            int               rawi, cur, err, lim_i, next_i, total, diff, dcap;
            if (chan >= NUM_CH)
                return;
            cmd.chan = chan;
            cmd.lim  = 1'b0;
            if (brake && chan == BRAKE_CHAN)
            begin
                // Position loop: saturating error total, derivative on the raw error.
                total = brk_total + int'(aerr);
                if (total > TOTAL_MAX)
                    total = TOTAL_MAX;
                if (total < TOTAL_MIN)
                    total = TOTAL_MIN;
                diff      = int'(aerr) - brk_last;
                brk_total = total;
                brk_last  = int'(aerr);
                acc = longint'(brk_kp) * longint'(aerr) + longint'(brk_kd) * longint'(diff)
                    + longint'(brk_ki) * longint'(total);
                mag = round_mag(acc, 13);
                if (mag > DUTY_FULL)
                begin
                    mag     = 64'(DUTY_FULL);
                    cmd.lim = 1'b1;
                end
                cmd.duty = mag[15:0];
                cmd.dir  = (acc < 0);
            end
            else
            begin
                // Current loop: convert the sample, clamp the integrator, add feedforward.
                rawi   = int'(raw);
                cur    = 15360 - ((rawi * 15 + 16) >> 5);
                err    = int'(target) - cur;
                lim_i  = int'(integ_limit);
                next_i = integ[chan] + err;
                if (next_i > lim_i)
                    next_i = lim_i;
                if (next_i < -lim_i)
                    next_i = -lim_i;
                integ[chan] = next_i;
                acc = longint'(gain_p) * longint'(err) + longint'(gain_i) * longint'(next_i)
                    + longint'(FF_RES_GAIN) * longint'(target)
                    + longint'(FF_SPEED_GAIN) * longint'(speed);
                mag  = round_mag(acc, 11);
                dcap = (int'(duty_cap) > DUTY_FULL) ? DUTY_FULL : int'(duty_cap);
                if (mag > dcap)
                begin
                    mag     = 64'(dcap);
                    cmd.lim = 1'b1;
                end
                cmd.duty = mag[15:0];
                cmd.dir  = (acc < 0);
                if (target == 0)
                begin
                    cmd.duty = '0;
                    cmd.dir  = 1'b1;
                    cmd.lim  = 1'b0;
                end
            end
            pending.push_back(cmd);
        endfunction

        function void check_command(logic [23:0] word);
            drive_cmd_t want;
            if (pending.size() == 0)
            begin
                $error("drive command %h arrived with no sample waiting", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (word[1:0] !== want.chan)
            begin
                $error("out_channel: expected %0d, got %0d", want.chan, word[1:0]);
                errors++;
            end
            if (word[17:2] !== want.duty)
            begin
                $error("duty: expected %0d, got %0d", want.duty, word[17:2]);
                errors++;
            end
            if (word[18] !== want.dir)
            begin
                $error("direction: expected %0d, got %0d", want.dir, word[18]);
                errors++;
            end
            if (word[19] !== want.lim)
            begin
                $error("limited: expected %0d, got %0d", want.lim, word[19]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    drive_scoreboard sb;
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    int stall_left = 0;
    int quiet = 0;
    int n_sent = 0;
    int n_ignored = 0;
    int n_brake = 0;
    int n_settings = 0;

    motor_current_pi_with_brake_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(0, 255);
            5, 6, 7: return $urandom_range(0, 131071);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls unless this phase runs without them.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if (!take_calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Sample every handshake at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.set_register(cfg_index, cfg_data);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_command(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_sent++;
                if (s_axis_tdata[1:0] >= NUM_CH)
                    n_ignored++;
                else if (s_axis_tdata[1:0] == 2 && s_axis_tuser)
                    n_brake++;
                sb.note_sample(s_axis_tdata[1:0], s_axis_tdata[17:2], s_axis_tdata[33:18],
                               s_axis_tdata[49:34], s_axis_tuser, s_axis_tdata[65:50]);
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $error("no item moved for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic [1:0] chan, input logic [15:0] raw,
                               input logic [15:0] speed, input logic [15:0] target,
                               input logic brake, input logic [15:0] aerr);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {6'd0, aerr, target, speed, raw, chan};
        s_axis_tuser  = brake;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_all(input logic [31:0] gp, input logic [31:0] gi,
                               input logic [31:0] il, input logic [31:0] dl,
                               input logic [31:0] bp, input logic [31:0] bd,
                               input logic [31:0] bi);
        program_reg(mcpi_brk_pkg::REG_CURRENT_GAIN_P, gp);
        program_reg(mcpi_brk_pkg::REG_CURRENT_GAIN_I, gi);
        program_reg(mcpi_brk_pkg::REG_INTEGRATOR_LIMIT, il);
        program_reg(mcpi_brk_pkg::REG_DUTY_LIMIT, dl);
        program_reg(mcpi_brk_pkg::REG_BRAKE_GAIN_P, bp);
        program_reg(mcpi_brk_pkg::REG_BRAKE_GAIN_D, bd);
        program_reg(mcpi_brk_pkg::REG_BRAKE_GAIN_I, bi);
        n_settings++;
    endtask

    // Drain all expected commands, then let the block sit idle.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    // One random sample. A nonzero push biases channel 2 into long brake runs
    // with a one-sided angle error so the brake error total reaches its rails.
    task automatic send_random(input int push);
        logic [1:0]  chan;
        logic [15:0] raw, speed, target, aerr;
        logic        brake;
        int          r, cur, val;
        raw = 16'($urandom);
        r   = $urandom_range(0, 99);
        if (push != 0 && r < 85)
        begin
            chan  = 2'd2;
            brake = 1'b1;
            if ($urandom_range(0, 19) == 0)
                val = $urandom_range(0, 65535) - 32768;
            else if (push > 0)
                val = $urandom_range(28672, 32767);
            else
                val = -int'($urandom_range(28672, 32768));
            aerr = val[15:0];
        end
        else
        begin
            chan  = (r < 3) ? 2'd3 : 2'($urandom_range(0, 2));
            brake = ($urandom_range(0, 2) == 0);
            aerr  = 16'($urandom);
        end
        if ($urandom_range(0, 1) == 0)
            speed = 16'($urandom);
        else
            speed = 16'($urandom_range(0, 511) - 256);
        // Targets: sometimes zero, often anywhere, often close to the measured current.
        r = $urandom_range(0, 19);
        if (r == 0)
            target = '0;
        else if (r < 10)
            target = 16'($urandom);
        else
        begin
            cur    = 15360 - ((int'(raw) * 15 + 16) >> 5);
            val    = cur + $urandom_range(0, 1023) - 512;
            target = val[15:0];
        end
        send_sample(chan, raw, speed, target, brake, aerr);
    endtask

    initial
    begin
        int push;
        int count;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed samples at the reset settings: field extremes, zero target, the unused
        // channel and brake requests, on channel 2 and on channels that cannot brake.
        send_sample(2'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
        send_sample(2'd1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'hFFFF);
        send_sample(2'd2, 16'd0, 16'h8000, 16'h8000, 1'b0, 16'h8000);
        send_sample(2'd0, 16'h8000, 16'd0, 16'd1, 1'b0, 16'd0);
        send_sample(2'd1, 16'd21845, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
        send_sample(2'd3, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h7FFF);
        send_sample(2'd3, 16'd0, 16'h8000, 16'h8000, 1'b1, 16'h8000);
        send_sample(2'd0, 16'd30000, 16'd256, 16'd512, 1'b1, 16'h7FFF);
        send_sample(2'd1, 16'd35000, 16'hFF00, 16'hFE00, 1'b1, 16'h8000);
        send_sample(2'd2, 16'd16384, 16'd100, 16'd1000, 1'b0, 16'd0);
        send_sample(2'd2, 16'd16384, 16'd0, 16'd0, 1'b1, 16'd4096);

        // Moderate brake gains and a duty limit above full scale.
        wait_idle();
        program_all(32'd21845, 32'd2185, 32'd32767, 32'd65535, 32'd8192, 32'd64, 32'd2);
        send_sample(2'd2, 16'd0, 16'd0, 16'd0, 1'b1, 16'h7FFF);
        send_sample(2'd2, 16'd0, 16'd0, 16'd0, 1'b1, 16'h8000);
        send_sample(2'd2, 16'd0, 16'd0, 16'd0, 1'b1, 16'd4096);
        send_sample(2'd2, 16'd0, 16'd0, 16'd0, 1'b1, 16'hFFFF);
        send_sample(2'd2, 16'd40000, 16'd300, 16'd2048, 1'b0, 16'd5000);
        send_sample(2'd2, 16'd0, 16'd0, 16'd0, 1'b1, 16'd100);
        send_sample(2'd0, 16'hFFFF, 16'h8000, 16'd0, 1'b0, 16'd0);
        send_sample(2'd1, 16'd32768, 16'd10, 16'd20, 1'b0, 16'd0);

        // Random phases: all-ones and all-zero settings first, then runs that
        // drive the brake total to each rail, then mixed settings.
        for (int phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            if (phase == 0)
                program_all('1, '1, 32'h7FFF, 32'hFFFF, '1, '1, '1);
            else if (phase == 1)
                program_all('0, '0, '0, '0, '0, '0, '0);
            else
                program_all(pick_gain(), pick_gain(),
                            ($urandom_range(0, 3) == 0) ? 32'h7FFF : $urandom_range(0, 4095),
                            ($urandom_range(0, 3) == 0) ? 32'h8000 : $urandom_range(0, 65535),
                            pick_gain(), pick_gain(), pick_gain());
            push      = (phase == 2 || phase == 3) ? 1 : (phase >= 4 && phase <= 6) ? -1 : 0;
            count     = (push != 0) ? 220 : 100;
            send_calm = ($urandom_range(0, 3) == 0);
            take_calm = ($urandom_range(0, 3) == 0);
            repeat (count) send_random(push);
        end

        wait_idle();
        $display("Sent %0d samples (%0d on the unused channel, %0d brake requests on channel 2)",
                 n_sent, n_ignored, n_brake);
        $display("Checked %0d drive commands across %0d register settings",
                 sb.checked, n_settings);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
